// ===== hdl/svc_pkg.sv =====
// Shared types and constants for the SVPWM compare calculator.
`timescale 1ns / 1ps

package svc_pkg;

    localparam int DEF_VOLT_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int NUM_PHASES     = 3;
    localparam int CMP_WIDTH      = 16;

    localparam logic [CMP_WIDTH-1:0] PERIOD_RESET = 16'd4250;

    // m_tuser bit positions
    localparam int TUSER_CLIP     = 0;
    localparam int TUSER_BUS_ZERO = 1;
    localparam int TUSER_WIDTH    = 2;

    // per-phase result leaving a lane
    typedef struct packed {
        logic [CMP_WIDTH-1:0] compare;
        logic                 clip;
    } svc_lane_out_t;

    // control tag that travels beside the lanes
    typedef struct packed {
        logic valid;
        logic bus_zero;
    } svc_tag_t;

    // one finished output beat; compare_a sits in the low bits
    typedef struct packed {
        logic                 bus_zero;
        logic                 clipped;
        logic [CMP_WIDTH-1:0] compare_c;
        logic [CMP_WIDTH-1:0] compare_b;
        logic [CMP_WIDTH-1:0] compare_a;
    } svc_beat_t;

endpackage

// ===== hdl/svc_zseq.sv =====
// Zero-sequence stage: min/max of the phases and per-phase offset magnitude and sign.
`timescale 1ns / 1ps

module svc_zseq #(
    parameter int VOLT_WIDTH = svc_pkg::DEF_VOLT_WIDTH
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [VOLT_WIDTH-1:0] volt [svc_pkg::NUM_PHASES],
    input  logic        [VOLT_WIDTH-1:0] bus_in,
    output logic        [VOLT_WIDTH-1:0] mag  [svc_pkg::NUM_PHASES],
    output logic                         neg  [svc_pkg::NUM_PHASES],
    output logic        [VOLT_WIDTH-1:0] bus_out
);

    localparam int SW = VOLT_WIDTH + 2;

    logic signed [VOLT_WIDTH-1:0] mx;
    logic signed [VOLT_WIDTH-1:0] mn;
    logic signed [SW-1:0]         sum_mm;
    logic        [VOLT_WIDTH-1:0] mag_reg [svc_pkg::NUM_PHASES];
    logic                         neg_reg [svc_pkg::NUM_PHASES];
    logic        [VOLT_WIDTH-1:0] bus_reg;

    always_comb
    begin
        mx = volt[0];
        mn = volt[0];
        for (int k = 1; k < svc_pkg::NUM_PHASES; k++)
        begin
            if (volt[k] > mx)
                mx = volt[k];
            if (volt[k] < mn)
                mn = volt[k];
        end
        sum_mm = SW'(mx) + SW'(mn);
    end

    // s = 2v - (max + min); |s| never exceeds max - min, so it fits VOLT_WIDTH bits
    for (genvar k = 0; k < svc_pkg::NUM_PHASES; k++)
    begin : g_phase
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] s_abs;

        always_comb
        begin
            s     = (SW'(volt[k]) <<< 1) - sum_mm;
            s_abs = s[SW-1] ? -s : s;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[k] <= s_abs[VOLT_WIDTH-1:0];
                neg_reg[k] <= s[SW-1];
            end
        end

        assign mag[k] = mag_reg[k];
        assign neg[k] = neg_reg[k];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            bus_reg <= bus_in;
    end

    assign bus_out = bus_reg;

endmodule

// ===== hdl/svc_lane.sv =====
// One phase lane: pipelined restoring divide, ratio clamp, period multiply, round and saturate.
`timescale 1ns / 1ps

module svc_lane #(
    parameter int VOLT_WIDTH = svc_pkg::DEF_VOLT_WIDTH,
    parameter int FRAC_BITS  = svc_pkg::DEF_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [VOLT_WIDTH-1:0]               mag,
    input  logic                                neg,
    input  logic [VOLT_WIDTH-1:0]               bus,
    input  logic [svc_pkg::CMP_WIDTH-1:0]       period,
    output svc_pkg::svc_lane_out_t              result
);

    localparam int NW = VOLT_WIDTH + FRAC_BITS + 1;   // dividend width
    localparam int DW = VOLT_WIDTH + 1;               // divisor width (2*bus)
    localparam int QW = FRAC_BITS + 1;                // quotient bits kept
    localparam int MW = FRAC_BITS + 2;                // half - ratio
    localparam int PERW = svc_pkg::CMP_WIDTH + 1;     // period as signed
    localparam int PW = MW + PERW;                    // product width
    localparam int TW = PW + 1;                       // rounded sum width
    localparam int RW = TW - FRAC_BITS;               // count after shift
    localparam int NS = FRAC_BITS + 1;                // divide stages

    localparam logic [QW-1:0] ONE_Q  = QW'(1) << FRAC_BITS;
    localparam logic [MW-1:0] HALF_M = MW'(1) << (FRAC_BITS - 1);
    localparam logic [TW-1:0] HALF_T = TW'(1) << (FRAC_BITS - 1);

    logic [NW-1:0] rem_reg [NS+1];
    logic [DW-1:0] den_reg [NS+1];
    logic [QW-1:0] quo_reg [NS+1];
    logic          sat_reg [NS+1];
    logic          neg_reg [NS+1];

    logic [NW-1:0] num_next;
    logic [DW-1:0] den_next;
    logic          sat_next;

    logic [QW-1:0]        q_clamp;
    logic signed [MW-1:0] m_next;
    logic signed [MW-1:0] m_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [TW-1:0] t_sum;
    logic [RW-1:0]        t_cnt;
    svc_pkg::svc_lane_out_t res_next;
    svc_pkg::svc_lane_out_t res_reg;

    // dividend = |s|*2^F + bus, divisor = 2*bus; a quotient of 2^(F+1) or more saturates
    always_comb
    begin
        num_next = (NW'(mag) << FRAC_BITS) + NW'(bus);
        den_next = {bus, 1'b0};
        sat_next = {1'b0, num_next} >= ((NW + 1)'(den_next) << (FRAC_BITS + 1));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_next;
            den_reg[0] <= den_next;
            quo_reg[0] <= '0;
            sat_reg[0] <= sat_next;
            neg_reg[0] <= neg;
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar i = 0; i < NS; i++)
    begin : g_div
        localparam int B = FRAC_BITS - i;
        logic [NW-1:0] dsh;
        logic          ge;

        always_comb
        begin
            dsh = NW'(den_reg[i]) << B;
            ge  = rem_reg[i] >= dsh;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? rem_reg[i] - dsh : rem_reg[i];
                den_reg[i+1] <= den_reg[i];
                quo_reg[i+1] <= quo_reg[i] | (QW'(ge) << B);
                sat_reg[i+1] <= sat_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // clamp ratio to 1.0, then half - signed ratio
    always_comb
    begin
        q_clamp = (sat_reg[NS] || (quo_reg[NS] > ONE_Q)) ? ONE_Q : quo_reg[NS];
        m_next  = neg_reg[NS] ? $signed(HALF_M + MW'(q_clamp))
                              : $signed(HALF_M - MW'(q_clamp));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            m_reg <= m_next;
    end

    assign prod_next = m_reg * $signed({1'b0, period});

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    // round halves up, then saturate to 0..period
    always_comb
    begin
        t_sum = TW'(prod_reg) + $signed(HALF_T);
        t_cnt = t_sum[TW-1:FRAC_BITS];
        if (t_sum[TW-1])
        begin
            res_next.compare = '0;
            res_next.clip    = 1'b1;
        end
        else if (t_cnt > RW'(period))
        begin
            res_next.compare = period;
            res_next.clip    = 1'b1;
        end
        else
        begin
            res_next.compare = t_cnt[svc_pkg::CMP_WIDTH-1:0];
            res_next.clip    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

// ===== hdl/svc_merge.sv =====
// Merge stage: combines lane results and flags, output register with skid slot.
`timescale 1ns / 1ps

module svc_merge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  svc_pkg::svc_lane_out_t                lane [svc_pkg::NUM_PHASES],
    input  svc_pkg::svc_tag_t                     tag,
    input  logic [svc_pkg::CMP_WIDTH-1:0]         period,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output svc_pkg::svc_beat_t                    out_beat,
    output logic                                  advance
);

    svc_pkg::svc_beat_t merged;
    svc_pkg::svc_beat_t out_reg;
    svc_pkg::svc_beat_t skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic               in_valid;
    logic [svc_pkg::CMP_WIDTH-1:0] mid;

    assign mid = period >> 1;

    always_comb
    begin
        if (tag.bus_zero)
        begin
            merged.compare_a = mid;
            merged.compare_b = mid;
            merged.compare_c = mid;
            merged.clipped   = 1'b0;
            merged.bus_zero  = 1'b1;
        end
        else
        begin
            merged.compare_a = lane[0].compare;
            merged.compare_b = lane[1].compare;
            merged.compare_c = lane[2].compare;
            merged.clipped   = lane[0].clip | lane[1].clip | lane[2].clip;
            merged.bus_zero  = 1'b0;
        end
    end

    // pipeline moves only while the skid slot is free
    assign advance  = !skid_valid_reg;
    assign in_valid = advance && tag.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
            out_reg <= skid_valid_reg ? skid_reg : merged;
        else if (in_valid)
            skid_reg <= merged;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

endmodule

// ===== hdl/svc_top_wrap_unused.sv =====
// Period register for the compare calculator.
`timescale 1ns / 1ps

module svc_period_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [svc_pkg::CMP_WIDTH-1:0] wdata,
    output logic [svc_pkg::CMP_WIDTH-1:0] period
);

    logic [svc_pkg::CMP_WIDTH-1:0] period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= svc_pkg::PERIOD_RESET;
        else if (we)
            period_reg <= wdata;
    end

    assign period = period_reg;

endmodule

// ===== hdl/svpwm_compare_calc.sv =====
// Top level: min/max zero-sequence SVPWM timer compare calculator, three parallel lanes.
// Pipeline: one zero-sequence stage, FRAC_BITS + 5 lane stages and one output register.
// Throughput: one beat per cycle while the skid slot is free; each lane's divider retires
//   one quotient bit per stage.
// Reset: rst_n clears all beat valids and loads period_counts with 4250; data regs keep junk.
`timescale 1ns / 1ps

module svpwm_compare_calc #(
    parameter int VOLT_WIDTH = svc_pkg::DEF_VOLT_WIDTH,
    parameter int FRAC_BITS  = svc_pkg::DEF_FRAC_BITS,
    localparam int IN_TDATA_W  = ((4 * VOLT_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = 3 * svc_pkg::CMP_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: period_counts
    input  logic                            cfg_we,
    input  logic [svc_pkg::CMP_WIDTH-1:0]   cfg_wdata,
    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_TDATA_W-1:0]           s_tdata,   // volt_a, volt_b, volt_c, bus_volt, zero pad
    // output beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_TDATA_W-1:0]          m_tdata,   // compare_a, compare_b, compare_c
    output logic [svc_pkg::TUSER_WIDTH-1:0] m_tuser    // clipped, bus_zero
);

    localparam int NP         = svc_pkg::NUM_PHASES;
    // zero-sequence stage plus the lane depth
    localparam int PIPE_DEPTH = FRAC_BITS + 6;

    logic [svc_pkg::CMP_WIDTH-1:0] period;
    logic                          advance;
    logic                          in_beat;

    logic signed [VOLT_WIDTH-1:0]  volt     [NP];
    logic        [VOLT_WIDTH-1:0]  bus_in;
    logic        [VOLT_WIDTH-1:0]  mag      [NP];
    logic                          neg      [NP];
    logic        [VOLT_WIDTH-1:0]  bus_q;
    svc_pkg::svc_lane_out_t        lane_res [NP];
    svc_pkg::svc_beat_t            out_beat;

    // valid / bus_zero tag line, one slot per pipeline stage
    svc_pkg::svc_tag_t             tag_reg  [PIPE_DEPTH];

    assign s_tready = advance;
    assign in_beat  = s_tvalid && advance;

    // unpack the input beat
    assign volt[0] = $signed(s_tdata[VOLT_WIDTH-1:0]);
    assign volt[1] = $signed(s_tdata[2*VOLT_WIDTH-1:VOLT_WIDTH]);
    assign volt[2] = $signed(s_tdata[3*VOLT_WIDTH-1:2*VOLT_WIDTH]);
    assign bus_in  = s_tdata[4*VOLT_WIDTH-1:3*VOLT_WIDTH];

    svc_period_reg u_period (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (cfg_we),
        .wdata  (cfg_wdata),
        .period (period)
    );

    svc_zseq #(
        .VOLT_WIDTH (VOLT_WIDTH)
    ) u_zseq (
        .clk     (clk),
        .en      (advance),
        .volt    (volt),
        .bus_in  (bus_in),
        .mag     (mag),
        .neg     (neg),
        .bus_out (bus_q)
    );

    // one lane per phase, all stepping together
    for (genvar k = 0; k < NP; k++)
    begin : g_lane
        svc_lane #(
            .VOLT_WIDTH (VOLT_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .en     (advance),
            .mag    (mag[k]),
            .neg    (neg[k]),
            .bus    (bus_q),
            .period (period),
            .result (lane_res[k])
        );
    end

    // tag line tracks which stages hold a live beat and its bus-zero flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
                tag_reg[i] <= '0;
        end
        else if (advance)
        begin
            tag_reg[0].valid    <= s_tvalid;
            tag_reg[0].bus_zero <= (bus_in == '0);
            for (int i = 1; i < PIPE_DEPTH; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    svc_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane      (lane_res),
        .tag       (tag_reg[PIPE_DEPTH-1]),
        .period    (period),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_beat  (out_beat),
        .advance   (advance)
    );

    assign m_tdata = {out_beat.compare_c, out_beat.compare_b, out_beat.compare_a};
    assign m_tuser[svc_pkg::TUSER_CLIP]     = out_beat.clipped;
    assign m_tuser[svc_pkg::TUSER_BUS_ZERO] = out_beat.bus_zero;

    // a full skid slot implies a held output beat
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("skid slot full with no output beat");

    // zero bus beats never report clipping
    a_bus_zero_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[svc_pkg::TUSER_BUS_ZERO]) |-> !m_tuser[svc_pkg::TUSER_CLIP])
        else $error("bus_zero beat flagged as clipped");

    // zero bus beats carry the same compare on all phases
    a_bus_zero_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[svc_pkg::TUSER_BUS_ZERO]) |->
        (out_beat.compare_a == out_beat.compare_b && out_beat.compare_b == out_beat.compare_c))
        else $error("bus_zero beat with unequal compares");

    // a stalled pipeline keeps its live beats in place
    a_stall_holds_tags: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tready && in_beat == 1'b0) |=> $stable(tag_reg[PIPE_DEPTH-1]))
        else $error("tag line moved during stall");

endmodule

// ===== verif/svpwm_compare_calc_test.sv =====
// Self-checking testbench for svpwm_compare_calc: predicted compare beats vs. DUT output stream.
`timescale 1ns / 1ps

module svpwm_compare_calc_test;

    localparam int  FRAC        = svc_pkg::DEF_FRAC_BITS;
    localparam int  LATENCY     = svc_pkg::DEF_FRAC_BITS + 7;
    localparam int  SETTLE      = LATENCY + 10;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  STALL_LEN   = 400;

    // ------------------------------------------------------------------
    // Compare tracker: holds a copy of the period register, predicts the
    // three compare counts for every accepted sample and checks beats in
    // order against them.
    // ------------------------------------------------------------------
    class compare_tracker;
        longint             period;
        svc_pkg::svc_beat_t pending_beats[$];
        int                 errors;
        int                 beats_checked;

        function new();
            period        = svc_pkg::PERIOD_RESET;
            errors        = 0;
            beats_checked = 0;
        endfunction

        function void set_period(logic [svc_pkg::CMP_WIDTH-1:0] p);
            period = p;
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction

        // One phase: s = 2*v - (max + min), ratio s/(2*bus) in Q.FRAC,
        // count = (0.5 - ratio) * period, rounded, saturated to 0..period.
        function svc_pkg::svc_lane_out_t predict_phase(longint s, longint bus);
            longint                 mag;
            longint                 q;
            longint                 r;
            longint                 t;
            svc_pkg::svc_lane_out_t o;
            mag = (s < 0) ? -s : s;
            q   = ((mag << FRAC) + bus) / (2 * bus);
            if (q > (longint'(1) << FRAC))
                q = longint'(1) << FRAC;
            r = (s < 0) ? -q : q;
            t = ((longint'(1) << (FRAC - 1)) - r) * period + (longint'(1) << (FRAC - 1));
            o.clip    = 1'b0;
            o.compare = '0;
            if (t < 0)
            begin
                o.clip = 1'b1;
            end
            else
            begin
                q = t >>> FRAC;
                if (q > period)
                begin
                    o.clip    = 1'b1;
                    o.compare = period[svc_pkg::CMP_WIDTH-1:0];
                end
                else
                begin
                    o.compare = q[svc_pkg::CMP_WIDTH-1:0];
                end
            end
            return o;
        endfunction

        // Accepted input beat: work out the output beat it must produce.
        function void note_sample(logic [63:0] d);
            longint                 v[3];
            longint                 bus;
            longint                 vmax;
            longint                 vmin;
            svc_pkg::svc_lane_out_t lane[3];
            svc_pkg::svc_beat_t     b;
            for (int k = 0; k < 3; k++)
                v[k] = longint'($signed(d[16*k +: 16]));
            bus = longint'(d[63:48]);
            b   = '0;
            if (bus == 0)
            begin
                // dead bus: park all phases at mid-period
                b.compare_a = period[svc_pkg::CMP_WIDTH:1];
                b.compare_b = period[svc_pkg::CMP_WIDTH:1];
                b.compare_c = period[svc_pkg::CMP_WIDTH:1];
                b.bus_zero  = 1'b1;
            end
            else
            begin
                vmax = v[0];
                vmin = v[0];
                for (int k = 1; k < 3; k++)
                begin
                    if (v[k] > vmax)
                        vmax = v[k];
                    if (v[k] < vmin)
                        vmin = v[k];
                end
                for (int k = 0; k < 3; k++)
                    lane[k] = predict_phase(2 * v[k] - (vmax + vmin), bus);
                b.compare_a = lane[0].compare;
                b.compare_b = lane[1].compare;
                b.compare_c = lane[2].compare;
                b.clipped   = lane[0].clip | lane[1].clip | lane[2].clip;
            end
            pending_beats.push_back(b);
        endfunction

        function void check_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v)
            begin
                errors++;
                if (errors <= 10)
                    $display("MISMATCH beat %0d %s: expected %0d, got %0d",
                             beats_checked, name, exp_v, act_v);
            end
        endfunction

        function void check_beat(svc_pkg::svc_beat_t act);
            svc_pkg::svc_beat_t exp_b;
            if (pending_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("UNEXPECTED output beat: a=%0d b=%0d c=%0d clip=%0b zero=%0b",
                             act.compare_a, act.compare_b, act.compare_c,
                             act.clipped, act.bus_zero);
                return;
            end
            exp_b = pending_beats.pop_front();
            check_field("compare_a", exp_b.compare_a, act.compare_a);
            check_field("compare_b", exp_b.compare_b, act.compare_b);
            check_field("compare_c", exp_b.compare_c, act.compare_c);
            check_field("clipped",   exp_b.clipped,   act.clipped);
            check_field("bus_zero",  exp_b.bus_zero,  act.bus_zero);
            beats_checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; the testbench-driven ones start at known values from time zero
    // ------------------------------------------------------------------
    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [svc_pkg::CMP_WIDTH-1:0]   cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [63:0]                     s_tdata   = '0;   // volt_a, volt_b, volt_c, bus_volt
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [47:0]                     m_tdata;          // compare_a, compare_b, compare_c
    logic [svc_pkg::TUSER_WIDTH-1:0] m_tuser;          // clipped, bus_zero

    compare_tracker tracker = new();

    int  tx_gap_pct  = 20;   // sender idle share, percent
    int  rx_idle_pct = 46;   // receiver idle share, percent
    bit  hold_req    = 1'b0; // asks the receiver for one long hold-off
    int  cycle_count = 0;
    int  settings    = 1;    // period settings seen (reset value counts)

    svpwm_compare_calc uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d beats outstanding",
                     cycle_count, tracker.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks each accepted beat, then picks next tready.
    // The long hold-off is counted here so the sender keeps pushing and
    // the pipeline backs up into s_tready.
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_beat({m_tuser[svc_pkg::TUSER_BUS_ZERO],
                                    m_tuser[svc_pkg::TUSER_CLIP], m_tdata});
            if (hold_req && stall_left == 0)
            begin
                stall_left = STALL_LEN;
                hold_req   = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------
    // One input beat; tvalid stays high into the next call when no gap is drawn.
    task automatic send_volts(input logic [15:0] va, input logic [15:0] vb,
                              input logic [15:0] vc, input logic [15:0] bus);
        while ($urandom_range(0, 99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bus, vc, vb, va};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_sample({bus, vc, vb, va});
    endtask

    // Wait for the pipe to empty, then write the period register.
    task automatic write_period(input logic [svc_pkg::CMP_WIDTH-1:0] p);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_period(p);
        settings++;
    endtask

    // Phase command: mostly inside +-bus, some slightly over, some anywhere in the 16-bit range.
    function automatic logic [15:0] pick_volt(logic [15:0] bus);
        int lim;
        int sel;
        lim = (bus > 32767) ? 32767 : int'(bus);
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            return 16'(int'($urandom_range(0, 2 * lim)) - lim);
        if (sel <= 7)
            return 16'($urandom);
        lim = lim + $urandom_range(0, 64);
        if (lim > 32767)
            lim = 32767;
        return ($urandom_range(0, 1) != 0) ? 16'(lim) : 16'(-lim);
    endfunction

    task automatic send_random(input int count);
        logic [15:0] bus;
        int          sel;
        repeat (count)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                bus = '0;
            else if (sel <= 2)
                bus = 16'($urandom_range(1, 15));
            else if (sel <= 8)
                bus = 16'($urandom_range(1, 65535));
            else
                bus = 16'($urandom_range(100, 40000));
            send_volts(pick_volt(bus), pick_volt(bus), pick_volt(bus), bus);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats at the reset period
        send_volts(0, 0, 0, 1000);
        send_volts(32767, 32767, 32767, 1);             // equal phases: mid-period compare
        send_volts(-32768, -32768, -32768, 65535);
        send_volts(32767, -32768, 0, 65535);
        send_volts(32767, -32768, 0, 1);                // ratio far past one
        send_volts(-32768, 32767, -1, 32768);
        send_volts(1000, -500, -500, 0);                // dead bus
        send_volts(-32768, 32767, 12345, 0);            // dead bus, extreme phases
        send_volts(1, 0, 0, 1);                         // rounding on a half
        send_volts(1, -1, 0, 3);
        send_volts(100, -50, -50, 100);
        send_volts(0, 1, -1, 65535);
        send_volts(32767, 0, 0, 32767);
        send_volts(-1, -1, -1, 1);
        send_volts(5000, -2500, -2500, 2887);           // near full modulation
        send_volts(20000, -20000, 0, 17320);
        send_volts(7, 3, -10, 9);
        send_volts(32767, 32767, -32768, 65535);

        // sender 20 %, receiver 46 % idle
        write_period(16'hFFFF);                         // full-scale period
        send_random(200);
        write_period(16'd1);                            // smallest legal period
        send_random(150);
        write_period(16'd0);                            // zero period: compares pinned at 0
        send_volts(-32768, 32767, 0, 65535);
        send_volts(0, 0, 0, 0);
        send_random(100);

        // roles swapped
        tx_gap_pct  = 46;
        rx_idle_pct = 20;
        write_period(16'($urandom_range(1, 65535)));
        send_random(300);

        // no idling; one long output hold-off to back the pipe up
        tx_gap_pct  = 0;
        rx_idle_pct = 0;
        write_period(svc_pkg::PERIOD_RESET);
        hold_req = 1'b1;
        send_random(500);

        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Checked %0d output beats over %0d period settings (0, 1, 65535 among them),",
                 tracker.beats_checked, settings);
        $display("with dead-bus and clipping cases, both idle mixes and a %0d-cycle output stall.",
                 STALL_LEN);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
